### sv/bpr_pkg.sv
package bpr_pkg;

  // Field widths of the two channels
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 2;
  localparam int FID_W   = 5;
  localparam int VALUE_W = 31;

  // Widths of the fixed header fields of a record
  localparam int NBITS_W    = 5;
  localparam int CX_NBITS_W = 4;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [FID_W-1:0] fid_t;
  typedef logic [4:0]       stage_t;

  // Record kinds, taken on the first byte of a record
  localparam cmd_t CMD_RECT     = 2'd0;
  localparam cmd_t CMD_MATRIX   = 2'd1;
  localparam cmd_t CMD_CXFORM   = 2'd2;
  localparam cmd_t CMD_RESERVED = 2'd3;

  // Decoder steps through a record
  localparam stage_t STG_IDLE           = 5'd0;
  localparam stage_t STG_RECT_NBITS     = 5'd1;
  localparam stage_t STG_RECT_XMIN      = 5'd2;
  localparam stage_t STG_RECT_XMAX      = 5'd3;
  localparam stage_t STG_RECT_YMIN      = 5'd4;
  localparam stage_t STG_RECT_YMAX      = 5'd5;
  localparam stage_t STG_MX_HAS_SCALE   = 5'd6;
  localparam stage_t STG_MX_SCALE_NBITS = 5'd7;
  localparam stage_t STG_MX_SCALE_X     = 5'd8;
  localparam stage_t STG_MX_SCALE_Y     = 5'd9;
  localparam stage_t STG_MX_HAS_ROT     = 5'd10;
  localparam stage_t STG_MX_ROT_NBITS   = 5'd11;
  localparam stage_t STG_MX_ROT_0       = 5'd12;
  localparam stage_t STG_MX_ROT_1       = 5'd13;
  localparam stage_t STG_MX_TRANS_NBITS = 5'd14;
  localparam stage_t STG_MX_TRANS_X     = 5'd15;
  localparam stage_t STG_MX_TRANS_Y     = 5'd16;
  localparam stage_t STG_CX_HAS_ADD     = 5'd17;
  localparam stage_t STG_CX_HAS_MULT    = 5'd18;
  localparam stage_t STG_CX_NBITS       = 5'd19;
  localparam stage_t STG_CX_MULT_R      = 5'd20;
  localparam stage_t STG_CX_MULT_G      = 5'd21;
  localparam stage_t STG_CX_MULT_B      = 5'd22;
  localparam stage_t STG_CX_MULT_A      = 5'd23;
  localparam stage_t STG_CX_ADD_R       = 5'd24;
  localparam stage_t STG_CX_ADD_G       = 5'd25;
  localparam stage_t STG_CX_ADD_B       = 5'd26;
  localparam stage_t STG_CX_ADD_A       = 5'd27;

  // Result field identifiers
  localparam fid_t FID_XMIN    = 5'd0;
  localparam fid_t FID_XMAX    = 5'd1;
  localparam fid_t FID_YMIN    = 5'd2;
  localparam fid_t FID_YMAX    = 5'd3;
  localparam fid_t FID_SCALE_X = 5'd4;
  localparam fid_t FID_SCALE_Y = 5'd5;
  localparam fid_t FID_ROT_0   = 5'd6;
  localparam fid_t FID_ROT_1   = 5'd7;
  localparam fid_t FID_TRANS_X = 5'd8;
  localparam fid_t FID_TRANS_Y = 5'd9;
  localparam fid_t FID_MULT_R  = 5'd10;
  localparam fid_t FID_MULT_G  = 5'd11;
  localparam fid_t FID_MULT_B  = 5'd12;
  localparam fid_t FID_MULT_A  = 5'd13;
  localparam fid_t FID_ADD_R   = 5'd14;
  localparam fid_t FID_ADD_G   = 5'd15;
  localparam fid_t FID_ADD_B   = 5'd16;
  localparam fid_t FID_ADD_A   = 5'd17;
  localparam fid_t FID_EMPTY   = 5'd18;

  // Queue entry between the front and the back
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              known;       // command was a valid record kind
    stage_t            start_stage; // first step if this byte opens a record
  } item_t;

  // First decoder step for each record kind
  function automatic stage_t start_stage_of(input cmd_t cmd);
    stage_t s;
    unique case (cmd)
      CMD_RECT:   s = STG_RECT_NBITS;
      CMD_MATRIX: s = STG_MX_HAS_SCALE;
      CMD_CXFORM: s = STG_CX_HAS_ADD;
      default:    s = STG_IDLE;
    endcase
    return s;
  endfunction

endpackage

### sv/bpr_if.sv
// Byte stream channel
interface bpr_in_if import bpr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [CMD_W-1:0]  command;

  modport source (output valid, output data_byte, output command, input ready);
  modport sink   (input valid, input data_byte, input command, output ready);
endinterface

// Decoded field channel
interface bpr_out_if import bpr_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [FID_W-1:0]          field_id;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output field_id, output value, output last, input ready);
  modport sink   (input valid, input field_id, input value, input last, output ready);
endinterface

### sv/bpr_front.sv
module bpr_front import bpr_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  bpr_in_if.sink     stream,
  output item_t      head,
  output logic       head_valid,
  input  logic       pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           push;
  logic           take;
  item_t          incoming;

  // Classify the transaction on the way in
  always_comb begin
    incoming.data_byte   = stream.data_byte;
    incoming.known       = (stream.command != CMD_RESERVED);
    incoming.start_stage = start_stage_of(stream.command);
  end

  assign stream.ready = (fill != CW'(DEPTH));
  assign push         = stream.valid && stream.ready;
  assign head_valid   = (fill != '0);
  assign take         = pop && head_valid;
  assign head         = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        fill <= fill + 1'b1;
      end else if (take && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### sv/bpr_back.sv
module bpr_back import bpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  item_t      head,
  input  logic       head_valid,
  output logic       pop,
  bpr_out_if.source  result
);

  // Reciprocal of 5 for a 29-bit dividend: floor(2^32 / 5) + 1
  localparam int         DIV_IN_W  = VALUE_W - 2;
  localparam int         DIV_SHIFT = 32;
  localparam logic [29:0] DIV5_MAGIC = 30'd858993460;
  localparam int         PROD_W    = DIV_IN_W + 30;
  localparam int         QUOT_W    = PROD_W - DIV_SHIFT;

  typedef enum logic [2:0] {
    PH_RUN = 3'b001,
    PH_MUL = 3'b010,
    PH_NEG = 3'b100
  } phase_t;

  // Bits each step consumes
  function automatic logic [4:0] stage_width(input stage_t s, input logic [4:0] fw);
    logic [4:0] w;
    unique case (s)
      STG_IDLE: w = '0;
      STG_RECT_NBITS, STG_MX_SCALE_NBITS, STG_MX_ROT_NBITS, STG_MX_TRANS_NBITS:
        w = 5'(NBITS_W);
      STG_MX_HAS_SCALE, STG_MX_HAS_ROT, STG_CX_HAS_ADD, STG_CX_HAS_MULT:
        w = 5'd1;
      STG_CX_NBITS: w = 5'(CX_NBITS_W);
      default: w = fw;
    endcase
    return w;
  endfunction

  // Result identifier given by each value step
  function automatic fid_t field_id_of(input stage_t s);
    fid_t f;
    unique case (s)
      STG_RECT_XMIN:  f = FID_XMIN;
      STG_RECT_XMAX:  f = FID_XMAX;
      STG_RECT_YMIN:  f = FID_YMIN;
      STG_RECT_YMAX:  f = FID_YMAX;
      STG_MX_SCALE_X: f = FID_SCALE_X;
      STG_MX_SCALE_Y: f = FID_SCALE_Y;
      STG_MX_ROT_0:   f = FID_ROT_0;
      STG_MX_ROT_1:   f = FID_ROT_1;
      STG_MX_TRANS_X: f = FID_TRANS_X;
      STG_MX_TRANS_Y: f = FID_TRANS_Y;
      STG_CX_MULT_R:  f = FID_MULT_R;
      STG_CX_MULT_G:  f = FID_MULT_G;
      STG_CX_MULT_B:  f = FID_MULT_B;
      STG_CX_MULT_A:  f = FID_MULT_A;
      STG_CX_ADD_R:   f = FID_ADD_R;
      STG_CX_ADD_G:   f = FID_ADD_G;
      STG_CX_ADD_B:   f = FID_ADD_B;
      STG_CX_ADD_A:   f = FID_ADD_A;
      default:        f = FID_EMPTY;
    endcase
    return f;
  endfunction

  // Decoder state
  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  held_byte, held_byte_next;
  logic [3:0]         bits_remaining, bits_remaining_next;
  stage_t             record_stage, record_stage_next;
  logic [4:0]         field_width, field_width_next;
  logic [1:0]         presence_flags, presence_flags_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [4:0]         bits_wanted, bits_wanted_next;

  // Divide-by-20 path for rectangle edges
  logic                div_neg, div_neg_next;
  logic [DIV_IN_W-1:0] div_mag, div_mag_next;
  logic [QUOT_W-1:0]   div_quot, div_quot_next;
  fid_t                div_id, div_id_next;
  logic                div_last, div_last_next;
  logic [PROD_W-1:0]   div_prod;

  // Output register load
  logic               emit_go;
  fid_t               emit_id;
  logic [VALUE_W-1:0] emit_value;
  logic               emit_last;
  logic               out_free;

  // Field value as seen at the end of a step
  logic [4:0]         fw_m1;
  logic               sign;
  logic [VALUE_W-1:0] sext;
  logic [VALUE_W-1:0] mag;
  logic [3:0]         br_m1;

  assign out_free = !result.valid || result.ready;
  assign fw_m1    = field_width - 5'd1;
  assign sign     = (field_width != '0) && accumulator[fw_m1];
  assign sext     = sign ? (accumulator | ({VALUE_W{1'b1}} << field_width)) : accumulator;
  assign mag      = sign ? (~sext + 1'b1) : sext;
  assign br_m1    = bits_remaining - 4'd1;
  assign div_prod = PROD_W'(div_mag) * PROD_W'(DIV5_MAGIC);

  // Step control: one bit, finished field or byte load per cycle while not stalled
  always_comb begin
    stage_t             ent;
    logic               ent_go;
    logic [4:0]         fw_new;
    logic [1:0]         flags_new;
    logic               emit_req;
    logic               div_req;
    logic [VALUE_W-1:0] val;

    phase_next          = phase;
    held_byte_next      = held_byte;
    bits_remaining_next = bits_remaining;
    record_stage_next   = record_stage;
    field_width_next    = field_width;
    presence_flags_next = presence_flags;
    accumulator_next    = accumulator;
    bits_wanted_next    = bits_wanted;
    div_neg_next        = div_neg;
    div_mag_next        = div_mag;
    div_quot_next       = div_quot;
    div_id_next         = div_id;
    div_last_next       = div_last;
    pop                 = 1'b0;
    emit_go             = 1'b0;
    emit_id             = div_id;
    emit_value          = '0;
    emit_last           = div_last;
    ent                 = STG_IDLE;
    ent_go              = 1'b0;
    fw_new              = field_width;
    flags_new           = presence_flags;
    emit_req            = 1'b0;
    div_req             = 1'b0;
    val                 = sext;

    unique case (phase)
      PH_RUN: begin
        if (record_stage != STG_IDLE && bits_wanted == '0) begin
          // A field is complete
          unique case (record_stage)
            STG_RECT_NBITS, STG_MX_SCALE_NBITS, STG_MX_ROT_NBITS, STG_MX_TRANS_NBITS: begin
              fw_new = accumulator[4:0];
              ent    = stage_t'(record_stage + 5'd1);
            end
            STG_CX_NBITS: begin
              fw_new = {1'b0, accumulator[3:0]};
              if (presence_flags[1]) begin
                ent = STG_CX_MULT_R;
              end else if (presence_flags[0]) begin
                ent = STG_CX_ADD_R;
              end else begin
                ent      = STG_IDLE;
                emit_req = 1'b1;
                val      = '0;
              end
            end
            STG_MX_HAS_SCALE: ent = accumulator[0] ? STG_MX_SCALE_NBITS : STG_MX_HAS_ROT;
            STG_MX_HAS_ROT:   ent = accumulator[0] ? STG_MX_ROT_NBITS : STG_MX_TRANS_NBITS;
            STG_CX_HAS_ADD: begin
              flags_new = {presence_flags[1], accumulator[0]};
              ent       = STG_CX_HAS_MULT;
            end
            STG_CX_HAS_MULT: begin
              flags_new = {accumulator[0], presence_flags[0]};
              ent       = STG_CX_NBITS;
            end
            STG_RECT_XMIN, STG_RECT_XMAX, STG_RECT_YMIN: begin
              div_req = 1'b1;
              ent     = stage_t'(record_stage + 5'd1);
            end
            STG_RECT_YMAX: begin
              div_req = 1'b1;
              ent     = STG_IDLE;
            end
            STG_MX_SCALE_X: begin emit_req = 1'b1; ent = STG_MX_SCALE_Y; end
            STG_MX_SCALE_Y: begin emit_req = 1'b1; ent = STG_MX_HAS_ROT; end
            STG_MX_ROT_0:   begin emit_req = 1'b1; ent = STG_MX_ROT_1; end
            STG_MX_ROT_1:   begin emit_req = 1'b1; ent = STG_MX_TRANS_NBITS; end
            STG_MX_TRANS_X: begin emit_req = 1'b1; ent = STG_MX_TRANS_Y; end
            STG_MX_TRANS_Y: begin emit_req = 1'b1; ent = STG_IDLE; end
            STG_CX_MULT_R, STG_CX_MULT_G, STG_CX_MULT_B,
            STG_CX_ADD_R, STG_CX_ADD_G, STG_CX_ADD_B: begin
              emit_req = 1'b1;
              val      = VALUE_W'(sext[7:0]);
              ent      = stage_t'(record_stage + 5'd1);
            end
            STG_CX_MULT_A: begin
              emit_req = 1'b1;
              val      = VALUE_W'(sext[7:0]);
              ent      = presence_flags[0] ? STG_CX_ADD_R : STG_IDLE;
            end
            STG_CX_ADD_A: begin
              emit_req = 1'b1;
              val      = VALUE_W'(sext[7:0]);
              ent      = STG_IDLE;
            end
            default: ent = STG_IDLE;
          endcase

          // Hold the step while the output register is still full
          if (!emit_req || out_free) begin
            ent_go              = 1'b1;
            field_width_next    = fw_new;
            presence_flags_next = flags_new;
            emit_go             = emit_req;
            emit_id             = field_id_of(record_stage);
            emit_value          = val;
            emit_last           = (ent == STG_IDLE);
            if (div_req) begin
              div_neg_next  = sign;
              div_mag_next  = mag[VALUE_W-1:2];
              div_id_next   = field_id_of(record_stage);
              div_last_next = (ent == STG_IDLE);
              phase_next    = PH_MUL;
            end
          end
        end else if (record_stage != STG_IDLE && bits_remaining != '0) begin
          // Shift in the next bit, MSB first
          accumulator_next    = {accumulator[VALUE_W-2:0], held_byte[br_m1[2:0]]};
          bits_wanted_next    = bits_wanted - 5'd1;
          bits_remaining_next = br_m1;
        end else begin
          // Byte used up or record closed: drop what is left, load the next byte
          bits_remaining_next = '0;
          pop                 = head_valid;
          if (head_valid) begin
            held_byte_next = head.data_byte;
            if (record_stage != STG_IDLE) begin
              bits_remaining_next = 4'd8;
            end else if (head.known) begin
              bits_remaining_next = 4'd8;
              presence_flags_next = '0;
              field_width_next    = '0;
              fw_new              = '0;
              ent                 = head.start_stage;
              ent_go              = 1'b1;
            end
          end
        end

        if (ent_go) begin
          record_stage_next = ent;
          accumulator_next  = '0;
          bits_wanted_next  = stage_width(ent, fw_new);
        end
      end
      PH_MUL: begin
        div_quot_next = div_prod[PROD_W-1:DIV_SHIFT];
        phase_next    = PH_NEG;
      end
      PH_NEG: begin
        if (out_free) begin
          emit_go    = 1'b1;
          emit_value = div_neg ? (~VALUE_W'(div_quot) + 1'b1) : VALUE_W'(div_quot);
          phase_next = PH_RUN;
        end
      end
      default: phase_next = PH_RUN;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_RUN;
      bits_remaining <= '0;
      record_stage   <= STG_IDLE;
      field_width    <= '0;
      presence_flags <= '0;
      accumulator    <= '0;
      bits_wanted    <= '0;
      result.valid   <= 1'b0;
    end else begin
      phase          <= phase_next;
      bits_remaining <= bits_remaining_next;
      record_stage   <= record_stage_next;
      field_width    <= field_width_next;
      presence_flags <= presence_flags_next;
      accumulator    <= accumulator_next;
      bits_wanted    <= bits_wanted_next;
      if (emit_go) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_byte <= held_byte_next;
    div_neg   <= div_neg_next;
    div_mag   <= div_mag_next;
    div_quot  <= div_quot_next;
    div_id    <= div_id_next;
    div_last  <= div_last_next;
    if (emit_go) begin
      result.field_id <= emit_id;
      result.value    <= emit_value;
      result.last     <= emit_last;
    end
  end

endmodule

### sv/bit_packed_record_decoder_unit.sv
// Bit-packed record decoder.
// stream carries one byte per transaction with a record kind on command
// (rectangle, matrix, colour transform); the kind is read only on the byte
// that opens a record, and a reserved kind drops that byte. result carries
// one decoded field per transaction with its identifier, signed value and a
// last flag on the final field of the record. Both channels use valid/ready.
// Bytes enter a small queue, so the next byte is taken while the decoder
// still works and while a result waits in the output register.
// The decoder does one step per cycle unless a full output register or the
// divide holds it: a byte is loaded, then each bit it uses is shifted in and
// each finished field closes a step, header fields included; a rectangle
// edge then goes through the divide by 20 (multiply by a reciprocal, then
// sign). A reserved kind at idle is dropped once loaded, and bits left in a
// byte after a record closes are dropped. A result enters the output register
// when its closing step ends, or in the sign phase for a rectangle edge.
// Reset empties the queue and the output register and returns the decoder to
// idle between records. While result is stalled the decoder holds at the next
// field it must deliver; the queue keeps taking bytes until it is full.
module bit_packed_record_decoder_unit import bpr_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  bpr_in_if.sink    stream,
  bpr_out_if.source result
);

  item_t head;
  logic  head_valid;
  logic  pop;

  bpr_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  bpr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

  // An empty colour transform is a single closing zero
  a_empty_record: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.field_id == FID_EMPTY |-> result.last && result.value == '0)
    else $error("empty record result malformed");

  // Only known field identifiers leave the block
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.field_id <= FID_EMPTY)
    else $error("field identifier out of range");

  // Colour terms carry the low byte only
  a_colour_byte: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.field_id >= FID_MULT_R && result.field_id <= FID_ADD_A
      |-> result.value[VALUE_W-1:8] == '0)
    else $error("colour value wider than a byte");

  // Nothing is offered straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid after reset");

endmodule

### dv/tb_bit_packed_record_decoder_unit.sv
`timescale 1ns / 1ps

module tb_bit_packed_record_decoder_unit;
  import bpr_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int ITEMS          = 380;
  localparam int QUIET_ITEMS    = 40;   // tail of the run with no idling
  localparam int LONG_HOLD      = 300;  // result stall that backs up the byte queue
  localparam int DRAIN_LIMIT    = 5_000;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_PER_BYTE   = 9;
  localparam longint TWIPS_PER_PIXEL = 20;
  localparam int NUM_DIRECTED   = 22;
  localparam int NUM_HAND       = 11;

  // One decoded field as it should leave the block
  typedef struct packed {
    fid_t                      id;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } field_rec_t;

  // One directed byte; by_hand rows carry their results typed in below
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    cmd_t              cmd;
    logic              by_hand;
    logic [2:0]        n_typed;
  } stim_row_t;

  // Directed bytes: reserved kind at idle, empty records, bit-packed records
  // spread over several bytes with stray commands on continuation bytes
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{8'hFF, CMD_RESERVED, 1'b1, 3'd0},  // reserved kind straight after reset
    '{8'h07, CMD_RECT,     1'b1, 3'd4},  // zero-width rectangle, ones dropped
    '{8'h3F, CMD_CXFORM,   1'b1, 3'd1},  // colour transform with no flags
    '{8'h01, CMD_MATRIX,   1'b1, 3'd2},  // translate only, width zero
    '{8'h00, CMD_RESERVED, 1'b1, 3'd0},
    // rectangle, width 8: -128, 127, -19, 20
    '{8'h44, CMD_RECT,     1'b0, 3'd0},
    '{8'h03, CMD_RESERVED, 1'b0, 3'd0},
    '{8'hFF, CMD_MATRIX,   1'b0, 3'd0},
    '{8'h68, CMD_CXFORM,   1'b0, 3'd0},
    '{8'hA7, CMD_RECT,     1'b0, 3'd0},
    // matrix with scale (width 3), rotate (width 1), translate (width 2)
    '{8'h8E, CMD_MATRIX,   1'b0, 3'd0},
    '{8'h38, CMD_RECT,     1'b0, 3'd0},
    '{8'h61, CMD_RESERVED, 1'b0, 3'd0},
    '{8'h48, CMD_CXFORM,   1'b0, 3'd0},
    // colour transform, mult and add, width 4
    '{8'hD2, CMD_CXFORM,   1'b0, 3'd0},
    '{8'h1F, CMD_RESERVED, 1'b0, 3'd0},
    '{8'hC0, CMD_MATRIX,   1'b0, 3'd0},
    '{8'h78, CMD_RECT,     1'b0, 3'd0},
    '{8'h20, CMD_CXFORM,   1'b0, 3'd0},
    '{8'h83, CMD_CXFORM,   1'b1, 3'd4},  // add only, width zero
    // mult only, width 1
    '{8'h46, CMD_CXFORM,   1'b0, 3'd0},
    '{8'h80, CMD_RESERVED, 1'b0, 3'd0}
  };

  localparam field_rec_t HAND_FIELDS [NUM_HAND] = '{
    '{FID_XMIN,    31'sd0, 1'b0},
    '{FID_XMAX,    31'sd0, 1'b0},
    '{FID_YMIN,    31'sd0, 1'b0},
    '{FID_YMAX,    31'sd0, 1'b1},
    '{FID_EMPTY,   31'sd0, 1'b1},
    '{FID_TRANS_X, 31'sd0, 1'b0},
    '{FID_TRANS_Y, 31'sd0, 1'b1},
    '{FID_ADD_R,   31'sd0, 1'b0},
    '{FID_ADD_G,   31'sd0, 1'b0},
    '{FID_ADD_B,   31'sd0, 1'b0},
    '{FID_ADD_A,   31'sd0, 1'b1}
  };

  logic clk = 1'b0;
  logic rst;

  bpr_in_if  stream_if ();
  bpr_out_if result_if ();

  bit_packed_record_decoder_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Decoder state as the stream walks through records
  stage_t          dec_stage;
  logic [4:0]      dec_width;   // width of the signed fields in hand
  logic [1:0]      dec_flags;   // bit 0 add present, bit 1 mult present
  logic [31:0]     dec_acc;
  logic [4:0]      dec_need;    // bits still owed to the current step
  int              dec_emitted;

  field_rec_t      owed_fields[$];
  bit              rec_bits[$];
  int              mismatches = 0;
  int              bytes_counted = 0;
  int              gap_pct = 0;
  bit              quiet_tail = 1'b0;
  bit              hold_request = 1'b0;

  // ---------------------------------------------------------------------
  // Field decoder
  // ---------------------------------------------------------------------

  function automatic logic [4:0] stage_bits(input stage_t s);
    case (s)
      STG_IDLE: return 5'd0;
      STG_RECT_NBITS, STG_MX_SCALE_NBITS, STG_MX_ROT_NBITS, STG_MX_TRANS_NBITS:
        return 5'(NBITS_W);
      STG_MX_HAS_SCALE, STG_MX_HAS_ROT, STG_CX_HAS_ADD, STG_CX_HAS_MULT:
        return 5'd1;
      STG_CX_NBITS: return 5'(CX_NBITS_W);
      default: return dec_width;
    endcase
  endfunction

  // Sign-extend the low w bits of raw
  function automatic longint field_value(input logic [31:0] raw, input logic [4:0] w);
    logic [31:0] mask;
    if (w == 5'd0) return 0;
    mask = (32'd1 << w) - 32'd1;
    raw = raw & mask;
    if (raw[w - 5'd1]) return longint'(raw) - (longint'(1) << w);
    return longint'(raw);
  endfunction

  task automatic go_stage(input stage_t s);
    dec_stage = s;
    dec_acc   = '0;
    dec_need  = stage_bits(s);
  endtask

  task automatic owe_field(input fid_t id, input longint v, input logic last);
    field_rec_t rec;
    if (dec_emitted >= MAX_PER_BYTE) return;
    rec.id    = id;
    rec.value = v[VALUE_W-1:0];
    rec.last  = last;
    owed_fields.insert(owed_fields.size(), rec);
    dec_emitted++;
  endtask

  // A step has all its bits: act on it and move to the next
  task automatic finish_stage();
    longint v;
    stage_t nxt;
    v = field_value(dec_acc, dec_width);
    case (dec_stage)
      STG_RECT_NBITS, STG_MX_SCALE_NBITS, STG_MX_ROT_NBITS, STG_MX_TRANS_NBITS: begin
        dec_width = dec_acc[4:0];
        go_stage(stage_t'(dec_stage + 5'd1));
      end
      STG_CX_NBITS: begin
        dec_width = {1'b0, dec_acc[3:0]};
        if (dec_flags[1]) begin
          go_stage(STG_CX_MULT_R);
        end else if (dec_flags[0]) begin
          go_stage(STG_CX_ADD_R);
        end else begin
          owe_field(FID_EMPTY, 0, 1'b1);
          go_stage(STG_IDLE);
        end
      end
      STG_MX_HAS_SCALE: go_stage(dec_acc[0] ? STG_MX_SCALE_NBITS : STG_MX_HAS_ROT);
      STG_MX_HAS_ROT:   go_stage(dec_acc[0] ? STG_MX_ROT_NBITS : STG_MX_TRANS_NBITS);
      STG_CX_HAS_ADD: begin
        dec_flags[0] = dec_acc[0];
        go_stage(STG_CX_HAS_MULT);
      end
      STG_CX_HAS_MULT: begin
        dec_flags[1] = dec_acc[0];
        go_stage(STG_CX_NBITS);
      end
      // rectangle edges go out in pixels, truncated toward zero
      STG_RECT_XMIN, STG_RECT_XMAX, STG_RECT_YMIN, STG_RECT_YMAX: begin
        owe_field(fid_t'(FID_XMIN + (dec_stage - STG_RECT_XMIN)), v / TWIPS_PER_PIXEL,
                  dec_stage == STG_RECT_YMAX);
        go_stage(dec_stage == STG_RECT_YMAX ? STG_IDLE : stage_t'(dec_stage + 5'd1));
      end
      STG_MX_SCALE_X: begin
        owe_field(FID_SCALE_X, v, 1'b0);
        go_stage(STG_MX_SCALE_Y);
      end
      STG_MX_SCALE_Y: begin
        owe_field(FID_SCALE_Y, v, 1'b0);
        go_stage(STG_MX_HAS_ROT);
      end
      STG_MX_ROT_0: begin
        owe_field(FID_ROT_0, v, 1'b0);
        go_stage(STG_MX_ROT_1);
      end
      STG_MX_ROT_1: begin
        owe_field(FID_ROT_1, v, 1'b0);
        go_stage(STG_MX_TRANS_NBITS);
      end
      STG_MX_TRANS_X: begin
        owe_field(FID_TRANS_X, v, 1'b0);
        go_stage(STG_MX_TRANS_Y);
      end
      STG_MX_TRANS_Y: begin
        owe_field(FID_TRANS_Y, v, 1'b1);
        go_stage(STG_IDLE);
      end
      // colour terms keep the low byte only
      STG_CX_MULT_R, STG_CX_MULT_G, STG_CX_MULT_B, STG_CX_MULT_A,
      STG_CX_ADD_R, STG_CX_ADD_G, STG_CX_ADD_B, STG_CX_ADD_A: begin
        if (dec_stage == STG_CX_MULT_A) nxt = dec_flags[0] ? STG_CX_ADD_R : STG_IDLE;
        else if (dec_stage == STG_CX_ADD_A) nxt = STG_IDLE;
        else nxt = stage_t'(dec_stage + 5'd1);
        owe_field(fid_t'(FID_MULT_R + (dec_stage - STG_CX_MULT_R)), v & 64'hFF,
                  nxt == STG_IDLE);
        go_stage(nxt);
      end
      default: go_stage(STG_IDLE);
    endcase
  endtask

  // Feed one accepted byte through the decoder, queueing the fields it closes
  task automatic decode_byte(input logic [BYTE_W-1:0] data, input cmd_t cmd);
    dec_emitted = 0;
    if (dec_stage == STG_IDLE) begin
      if (cmd == CMD_RESERVED) return;
      dec_flags = '0;
      dec_width = '0;
      case (cmd)
        CMD_RECT:   go_stage(STG_RECT_NBITS);
        CMD_MATRIX: go_stage(STG_MX_HAS_SCALE);
        default:    go_stage(STG_CX_HAS_ADD);
      endcase
    end
    // bits after the record's last field fall out of the loop
    for (int b = BYTE_W - 1; b >= 0 && dec_stage != STG_IDLE; b--) begin
      dec_acc = {dec_acc[30:0], data[b]};
      if (dec_need != 5'd0) dec_need--;
      while (dec_stage != STG_IDLE && dec_need == 5'd0) finish_stage();
    end
  endtask

  // ---------------------------------------------------------------------
  // Byte stream driver
  // ---------------------------------------------------------------------

  // Offer one byte at the falling edge, return at the edge that takes it
  task automatic send_byte(input logic [BYTE_W-1:0] data, input cmd_t cmd);
    int gap;
    gap = 0;
    if (!quiet_tail && gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
      gap = $urandom_range(1, 14);
    repeat (gap) begin
      @(negedge clk);
      stream_if.valid     <= 1'b0;
      stream_if.data_byte <= 8'($urandom);
    end
    @(negedge clk);
    stream_if.valid     <= 1'b1;
    stream_if.data_byte <= data;
    stream_if.command   <= cmd;
    do @(posedge clk); while (!stream_if.ready);
  endtask

  task automatic send_and_decode(input logic [BYTE_W-1:0] data, input cmd_t cmd);
    send_byte(data, cmd);
    // a reserved kind at idle is simply dropped; it does not count
    if (!(dec_stage == STG_IDLE && cmd == CMD_RESERVED)) bytes_counted++;
    decode_byte(data, cmd);
  endtask

  // ---------------------------------------------------------------------
  // Record builder
  // ---------------------------------------------------------------------

  function automatic int pick_width(input int maxw);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, (maxw < 10) ? maxw : 10);
    if (r < 9) return $urandom_range(0, maxw);
    return maxw;
  endfunction

  // Raw w-bit field, leaning on the signed extremes
  function automatic logic [31:0] pick_raw(input int w);
    logic [31:0] mask;
    if (w == 0) return '0;
    mask = (32'd1 << w) - 32'd1;
    case ($urandom_range(0, 7))
      0: return 32'd1 << (w - 1);
      1: return (32'd1 << (w - 1)) - 32'd1;
      2: return mask;
      3: return '0;
      default: return $urandom & mask;
    endcase
  endfunction

  task automatic put_bits(input logic [31:0] v, input int w);
    for (int i = w - 1; i >= 0; i--) rec_bits.insert(rec_bits.size(), v[i]);
  endtask

  // Well-formed record of a random kind, random content, padded with junk
  task automatic random_record();
    cmd_t            kind;
    int              w;
    logic            add_on;
    logic            mult_on;
    logic [BYTE_W-1:0] b;
    rec_bits.delete();
    kind = cmd_t'($urandom_range(0, 2));
    case (kind)
      CMD_RECT: begin
        w = pick_width(31);
        put_bits(w, NBITS_W);
        repeat (4) put_bits(pick_raw(w), w);
      end
      CMD_MATRIX: begin
        repeat (2) begin
          if ($urandom_range(0, 1) == 1) begin
            put_bits(1, 1);
            w = pick_width(31);
            put_bits(w, NBITS_W);
            repeat (2) put_bits(pick_raw(w), w);
          end else begin
            put_bits(0, 1);
          end
        end
        w = pick_width(31);
        put_bits(w, NBITS_W);
        repeat (2) put_bits(pick_raw(w), w);
      end
      default: begin
        add_on  = 1'($urandom_range(0, 1));
        mult_on = 1'($urandom_range(0, 1));
        put_bits(32'(add_on), 1);
        put_bits(32'(mult_on), 1);
        w = pick_width(15);
        put_bits(w, CX_NBITS_W);
        if (mult_on) repeat (4) put_bits(pick_raw(w), w);
        if (add_on) repeat (4) put_bits(pick_raw(w), w);
      end
    endcase
    while (rec_bits.size() % BYTE_W != 0)
      rec_bits.insert(rec_bits.size(), 1'($urandom_range(0, 1)));
    for (int k = 0; k < rec_bits.size(); k += BYTE_W) begin
      for (int j = 0; j < BYTE_W; j++) b = {b[BYTE_W-2:0], rec_bits[k + j]};
      // continuation bytes carry a random command, which must be ignored
      send_and_decode(b, (k == 0) ? kind : cmd_t'($urandom_range(0, 3)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin : stimulus
    int hand_idx;
    int queued;
    int waited;
    rst                 = 1'b1;
    stream_if.valid     = 1'b0;
    stream_if.data_byte = '0;
    stream_if.command   = CMD_RECT;
    dec_stage   = STG_IDLE;
    dec_width   = '0;
    dec_flags   = '0;
    dec_acc     = '0;
    dec_need    = '0;
    dec_emitted = 0;
    hand_idx    = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed bytes; typed rows replace the decoder's view of their fields
    gap_pct = 25;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].cmd);
      queued = owed_fields.size();
      decode_byte(DIRECTED[i].data, DIRECTED[i].cmd);
      if (DIRECTED[i].by_hand) begin
        while (owed_fields.size() > queued) void'(owed_fields.pop_back());
        repeat (DIRECTED[i].n_typed) begin
          owed_fields.insert(owed_fields.size(), HAND_FIELDS[hand_idx]);
          hand_idx++;
        end
      end
    end

    // random part: mostly whole records, some loose bytes
    hold_request = 1'b1;
    while (bytes_counted < ITEMS) begin
      if (bytes_counted >= ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      if ($urandom_range(0, 9) == 0) begin
        send_and_decode(8'($urandom), cmd_t'($urandom_range(0, 3)));
        while (dec_stage != STG_IDLE)
          send_and_decode(8'($urandom), cmd_t'($urandom_range(0, 3)));
      end else begin
        random_record();
      end
    end
    @(negedge clk);
    stream_if.valid <= 1'b0;

    // let the decoder drain, then watch for strays
    waited = 0;
    while (owed_fields.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_fields.size() != 0)
      $display("%0d decoded fields never arrived", owed_fields.size());

    if (mismatches == 0 && owed_fields.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int  n;
    bit  hold_taken;
    result_if.ready = 1'b0;
    hold_taken      = 1'b0;
    forever begin
      if (hold_request && !hold_taken && !quiet_tail) begin
        hold_taken = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          result_if.ready <= 1'b0;
        end
      end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 14);
        repeat (n) begin
          @(negedge clk);
          result_if.ready <= 1'b0;
        end
      end
      n = $urandom_range(1, 40);
      repeat (n) begin
        @(negedge clk);
        result_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // each result transaction against the oldest owed field
  always @(posedge clk) begin : check_fields
    field_rec_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (owed_fields.size() == 0) begin
        report_mismatch("unowed field_id", longint'(result_if.field_id), -1);
      end else begin
        want = owed_fields.pop_front();
        if (result_if.field_id !== want.id)
          report_mismatch("field_id", longint'(result_if.field_id), longint'(want.id));
        if (result_if.value !== want.value)
          report_mismatch("value", longint'(result_if.value), longint'(want.value));
        if (result_if.last !== want.last)
          report_mismatch("last", longint'(result_if.last), longint'(want.last));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
sv/bpr_pkg.sv
sv/bpr_if.sv
sv/bpr_front.sv
sv/bpr_back.sv
sv/bit_packed_record_decoder_unit.sv
dv/tb_bit_packed_record_decoder_unit.sv
